[design/tsi_pkg.sv]
// Package for the tabulated state interpolator: sizes, command and status codes,
// controller states and the controller/datapath command and status bundles. No dependencies.
package tsi_pkg;
	localparam int TABLE_DEPTH     = 1024;
	localparam int RATIO_FRAC_BITS = 24;
	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int TIME_W = 48;
	localparam int POS_W  = 48;
	localparam int VEL_W  = 40;
	localparam int RAT_W  = RATIO_FRAC_BITS + 1;
	localparam int SAMP_W = TIME_W + 3 * POS_W + 3 * VEL_W;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INTERP = 3'd0,
		ST_EXACT  = 3'd1,
		ST_RANGE  = 3'd2,
		ST_DONE   = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_APP_RD, S_APP_CHK, S_Q_RD, S_Q_WAIT, S_Q_DEC,
		S_DIV, S_MUL, S_OUT
	} state_t;

	typedef struct packed {
		logic load_item;
		logic rd_last;
		logic rd_pair;
		logic wr_sample;
		logic div_start;
		logic mul_start;
		logic set_result;
		status_t result_status;
		logic result_sel_hi;
		logic result_zero;
		logic result_interp;
		logic clear;
		logic idx_zero;
		logic idx_dec;
		logic idx_inc;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic idx_oob;
		logic has_next;
		logic idx_pos;
		logic app_low;
		logic t_lt_t0;
		logic t_eq_t0;
		logic t_eq_t1;
		logic t_le_t1;
		logic div_done;
		logic mul_done;
	} dp_stat_t;
endpackage

[design/tsi_if.sv]
// Valid/ready channel interfaces for the interpolator: input item and result.
// Depends on tsi_pkg.
interface tsi_in_if import tsi_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] command;
	logic [TIME_W-1:0] sample_time;
	logic [TIME_W-1:0] query_time;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
	modport source (output valid, command, sample_time, query_time,
		pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink (input valid, command, sample_time, query_time,
		pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface tsi_out_if import tsi_pkg::*; ();
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [TIME_W-1:0] out_time;
	logic signed [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [VEL_W-1:0] out_vel_x, out_vel_y, out_vel_z;
	modport source (output valid, status, out_time, out_pos_x, out_pos_y, out_pos_z,
		out_vel_x, out_vel_y, out_vel_z, input ready);
	modport sink (input valid, status, out_time, out_pos_x, out_pos_y, out_pos_z,
		out_vel_x, out_vel_y, out_vel_z, output ready);
endinterface

[design/tsi_ram.sv]
// Generic single-port RAM with registered read. No dependencies.
module tsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[design/tsi_ctrl.sv]
// Controller state machine: sequences clear, append, hunt walk, divide, multiply, output.
// Depends on tsi_pkg.
module tsi_ctrl import tsi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	state_t state_q, state_d;
	logic   ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d  = state_q;
		ov_d     = ov_q && !out_ready;
		cmd      = '0;
		cmd.result_status = ST_RANGE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = S_APP_RD;
				end
			end
			S_APP_RD: begin
				// decode latched item
				case (stat.cmd)
					CMD_CLEAR: begin
						cmd.clear = 1'b1;
						cmd.set_result = 1'b1;
						cmd.result_zero = 1'b1;
						cmd.result_status = ST_DONE;
						state_d = S_OUT;
					end
					CMD_APPEND: begin
						if (stat.full) begin
							cmd.set_result = 1'b1;
							cmd.result_zero = 1'b1;
							cmd.result_status = ST_FULL;
							state_d = S_OUT;
						end else begin
							cmd.rd_last = 1'b1;
							state_d = S_APP_CHK;
						end
					end
					CMD_QUERY: begin
						state_d = S_Q_RD;
					end
					default: begin
						cmd.set_result = 1'b1;
						cmd.result_zero = 1'b1;
						state_d = S_OUT;
					end
				endcase
			end
			S_APP_CHK: begin
				cmd.set_result = 1'b1;
				cmd.result_zero = 1'b1;
				if (!stat.empty && stat.app_low) begin
					cmd.result_status = ST_RANGE;
				end else begin
					cmd.wr_sample = 1'b1;
					cmd.result_status = ST_DONE;
				end
				state_d = S_OUT;
			end
			S_Q_RD: begin
				if (stat.idx_oob) begin
					cmd.idx_zero = 1'b1;
					cmd.set_result = 1'b1;
					cmd.result_zero = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.rd_pair = 1'b1;
					state_d = S_Q_WAIT;
				end
			end
			S_Q_WAIT: begin
				cmd.rd_pair = 1'b1;
				state_d = S_Q_DEC;
			end
			S_Q_DEC: begin
				cmd.set_result = 1'b1;
				cmd.result_zero = 1'b1;
				state_d = S_OUT;
				if (stat.has_next) begin
					if (!stat.t_lt_t0 && stat.t_le_t1) begin
						cmd.result_zero = 1'b0;
						if (stat.t_eq_t0) begin
							cmd.result_status = ST_EXACT;
						end else if (stat.t_eq_t1) begin
							cmd.result_status = ST_EXACT;
							cmd.result_sel_hi = 1'b1;
						end else begin
							cmd.set_result = 1'b0;
							cmd.div_start = 1'b1;
							state_d = S_DIV;
						end
					end else if (stat.t_lt_t0) begin
						if (stat.idx_pos) begin
							cmd.set_result = 1'b0;
							cmd.idx_dec = 1'b1;
							state_d = S_Q_RD;
						end
					end else begin
						cmd.set_result = 1'b0;
						cmd.idx_inc = 1'b1;
						state_d = S_Q_RD;
					end
				end else begin
					if (stat.t_eq_t0) begin
						cmd.result_zero = 1'b0;
						cmd.result_status = ST_EXACT;
					end else if (stat.t_lt_t0 && stat.idx_pos) begin
						cmd.set_result = 1'b0;
						cmd.idx_dec = 1'b1;
						state_d = S_Q_RD;
					end
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.mul_start = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (stat.mul_done) begin
					cmd.set_result = 1'b1;
					cmd.result_interp = 1'b1;
					cmd.result_status = ST_INTERP;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!ov_q || out_ready) begin
					ov_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

[design/tsi_dp.sv]
// Datapath: sample RAMs, entry count, cached index, bit-serial divider,
// shared serial lerp multiplier and result register. Depends on tsi_pkg, tsi_ram.
module tsi_dp import tsi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic [1:0]               in_command,
	input  logic [TIME_W-1:0]        in_sample_time,
	input  logic [TIME_W-1:0]        in_query_time,
	input  logic [3*POS_W-1:0]       in_pos,
	input  logic [3*VEL_W-1:0]       in_vel,
	output status_t                  res_status,
	output logic [TIME_W-1:0]        res_time,
	output logic [3*POS_W-1:0]       res_pos,
	output logic [3*VEL_W-1:0]       res_vel
);
	localparam int MAG_W = POS_W;
	localparam int PROD_W = MAG_W + RAT_W;

	cmd_t                cmd_q;
	logic [TIME_W-1:0]   st_q, qt_q;
	logic [3*POS_W-1:0]  ipos_q;
	logic [3*VEL_W-1:0]  ivel_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;
	logic                phase_q;

	// two banks: even and odd entries, so a pair reads in one access each
	logic [IDX_W-2:0]    addr_e, addr_o;
	logic                we_e, we_o;
	logic [SAMP_W-1:0]   wdata, rd_e, rd_o;
	logic [IDX_W-1:0]    idx_p1, rd_addr;
	logic [SAMP_W-1:0]   s0, s1;
	logic [TIME_W-1:0]   t0, t1;

	assign idx_p1 = idx_q + 1'b1;
	assign rd_addr = cmd.rd_last ? IDX_W'(count_q - 1'b1) : idx_q;
	assign wdata = {st_q, ipos_q, ivel_q};
	assign we_e = cmd.wr_sample && !count_q[0];
	assign we_o = cmd.wr_sample && count_q[0];
	always_comb begin
		if (cmd.wr_sample) begin
			addr_e = count_q[IDX_W-1:1];
			addr_o = count_q[IDX_W-1:1];
		end else if (rd_addr[0]) begin
			addr_o = rd_addr[IDX_W-1:1];
			addr_e = idx_p1[IDX_W-1:1];
		end else begin
			addr_e = rd_addr[IDX_W-1:1];
			addr_o = rd_addr[IDX_W-1:1];
		end
	end

	tsi_ram #(.WIDTH(SAMP_W), .DEPTH(TABLE_DEPTH / 2)) u_ram_e (
		.clk(clk), .we(we_e), .addr(addr_e), .wdata(wdata), .rdata(rd_e));
	tsi_ram #(.WIDTH(SAMP_W), .DEPTH(TABLE_DEPTH / 2)) u_ram_o (
		.clk(clk), .we(we_o), .addr(addr_o), .wdata(wdata), .rdata(rd_o));

	assign s0 = phase_q ? rd_o : rd_e;
	assign s1 = phase_q ? rd_e : rd_o;
	assign t0 = s0[SAMP_W-1 -: TIME_W];
	assign t1 = s1[SAMP_W-1 -: TIME_W];

	always_ff @(posedge clk) begin
		phase_q <= rd_addr[0];
		if (cmd.load_item) begin
			cmd_q  <= cmd_t'(in_command);
			st_q   <= in_sample_time;
			qt_q   <= in_query_time;
			ipos_q <= in_pos;
			ivel_q <= in_vel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				idx_q   <= '0;
			end else begin
				if (cmd.wr_sample) count_q <= count_q + 1'b1;
				if (cmd.idx_zero) idx_q <= '0;
				else if (cmd.idx_dec) idx_q <= idx_q - 1'b1;
				else if (cmd.idx_inc) idx_q <= idx_p1;
			end
		end
	end

	// restoring divider, one quotient bit per cycle, then round
	logic [TIME_W:0]           rem_q;
	logic [TIME_W-1:0]         den_q;
	logic [RAT_W-1:0]          quo_q;
	logic [$clog2(RAT_W+1)-1:0] dcnt_q;
	logic                      dbusy_q, ddone_q;
	logic [TIME_W+1:0]         rem2;

	assign rem2 = {rem_q, 1'b0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			ddone_q <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dbusy_q <= 1'b1;
				dcnt_q  <= '0;
				rem_q   <= {1'b0, qt_q - t0};
				den_q   <= t1 - t0;
				quo_q   <= '0;
			end else if (dbusy_q) begin
				if (dcnt_q == ($bits(dcnt_q))'(RATIO_FRAC_BITS)) begin
					if (rem2 >= {2'b0, den_q}) quo_q <= quo_q + 1'b1;
					dbusy_q <= 1'b0;
					ddone_q <= 1'b1;
				end else begin
					dcnt_q <= dcnt_q + 1'b1;
					if (rem2 >= {2'b0, den_q}) begin
						rem_q <= (TIME_W+1)'(rem2 - {2'b0, den_q});
						quo_q <= {quo_q[RAT_W-2:0], 1'b1};
					end else begin
						rem_q <= rem2[TIME_W:0];
						quo_q <= {quo_q[RAT_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	// lerp: six components through one 48x25 multiplier, one per cycle, registered
	logic [SAMP_W-1:0]   a_q, b_q;
	logic [2:0]          lane_q;
	logic                mbusy_q, mdone_q, mv_s1;
	logic [MAG_W:0]      a0, a1;
	logic                neg, neg_s1;
	logic [MAG_W:0]      diff;
	logic [MAG_W-1:0]    mag;
	logic [PROD_W-1:0]   prod_s1;
	logic [MAG_W:0]      a0_s1;
	logic [2:0]          lane_s1;
	logic [MAG_W-1:0]    q;
	logic [MAG_W:0]      lerp_v;
	logic [3*POS_W-1:0]  lp_q;
	logic [3*VEL_W-1:0]  lv_q;

	always_comb begin
		if (lane_q < 3'd3) begin
			a0 = (MAG_W+1)'(signed'(a_q[3*VEL_W + (2-lane_q)*POS_W +: POS_W]));
			a1 = (MAG_W+1)'(signed'(b_q[3*VEL_W + (2-lane_q)*POS_W +: POS_W]));
		end else begin
			a0 = (MAG_W+1)'(signed'(a_q[(5-lane_q)*VEL_W +: VEL_W]));
			a1 = (MAG_W+1)'(signed'(b_q[(5-lane_q)*VEL_W +: VEL_W]));
		end
		neg  = $signed(a1) < $signed(a0);
		diff = neg ? a0 - a1 : a1 - a0;
		mag  = diff[MAG_W-1:0];
	end

	assign q = MAG_W'((prod_s1 + (PROD_W'(1) << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS);
	assign lerp_v = neg_s1 ? a0_s1 - {1'b0, q} : a0_s1 + {1'b0, q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mv_s1   <= 1'b0;
		end else begin
			mdone_q <= 1'b0;
			mv_s1   <= mbusy_q;
			if (cmd.mul_start) begin
				mbusy_q <= 1'b1;
				lane_q  <= '0;
			end else if (mbusy_q) begin
				lane_q <= lane_q + 1'b1;
				if (lane_q == 3'd5) mbusy_q <= 1'b0;
			end
			if (mv_s1 && lane_s1 == 3'd5) mdone_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			a_q <= s0;
			b_q <= s1;
		end
		prod_s1 <= PROD_W'(mag) * PROD_W'(quo_q);
		neg_s1  <= neg;
		a0_s1   <= a0;
		lane_s1 <= lane_q;
		if (mv_s1) begin
			if (lane_s1 < 3'd3) lp_q[(2-lane_s1)*POS_W +: POS_W] <= lerp_v[POS_W-1:0];
			else lv_q[(5-lane_s1)*VEL_W +: VEL_W] <= lerp_v[VEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_result) begin
			res_status <= cmd.result_status;
			if (cmd.result_zero) begin
				res_time <= '0;
				res_pos  <= '0;
				res_vel  <= '0;
			end else if (cmd.result_interp) begin
				res_time <= qt_q;
				res_pos  <= lp_q;
				res_vel  <= lv_q;
			end else if (cmd.result_sel_hi) begin
				{res_time, res_pos, res_vel} <= s1;
			end else begin
				{res_time, res_pos, res_vel} <= s0;
			end
		end
	end

	always_comb begin
		stat.cmd      = cmd_q;
		stat.full     = count_q >= CNT_W'(TABLE_DEPTH);
		stat.empty    = count_q == '0;
		stat.idx_oob  = {1'b0, idx_q} >= count_q;
		stat.has_next = {1'b0, idx_p1} < count_q && idx_q != IDX_W'(TABLE_DEPTH - 1);
		stat.idx_pos  = idx_q != '0;
		stat.app_low  = st_q < t0;
		stat.t_lt_t0  = qt_q < t0;
		stat.t_eq_t0  = qt_q == t0;
		stat.t_eq_t1  = qt_q == t1;
		stat.t_le_t1  = qt_q <= t1;
		stat.div_done = ddone_q;
		stat.mul_done = mdone_q;
	end
endmodule

[design/tabulated_state_interpolator_core.sv]
// Top level of the tabulated state interpolator: controller plus datapath.
// Depends on tsi_pkg, tsi_if, tsi_ctrl, tsi_dp.
//
//  channel | modport | carries
//  in      | sink    | command, sample_time, query_time, pos_*, vel_*
//  out     | source  | status, out_time, out_pos_*, out_vel_*
//
// One transaction at a time. Clear/full/unused go from decode to output; append adds
// a read of the last entry and an order check. Query: each hunt step (one paired RAM read)
// passes the read, wait and decode states, then divide and multiply when interpolating.
// Reset clears entry count and cached index; the sample RAM is not cleared.
// A stalled result holds in the output register; the next transaction is
// taken while it waits.
module tabulated_state_interpolator_core import tsi_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	tsi_in_if.sink  in,
	tsi_out_if.source out
);
	dp_cmd_t  cmd;
	dp_stat_t stat;
	status_t  res_status;

	tsi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready),
		.stat(stat), .cmd(cmd)
	);

	// result registers only update in S_OUT preceding states, output buffer below
	logic [TIME_W-1:0]  r_time;
	logic [3*POS_W-1:0] r_pos;
	logic [3*VEL_W-1:0] r_vel;

	tsi_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_command(in.command), .in_sample_time(in.sample_time),
		.in_query_time(in.query_time),
		.in_pos({in.pos_x, in.pos_y, in.pos_z}),
		.in_vel({in.vel_x, in.vel_y, in.vel_z}),
		.res_status(res_status), .res_time(r_time), .res_pos(r_pos), .res_vel(r_vel)
	);

	logic hold_q;
	logic [2:0] st_q;
	logic [TIME_W-1:0] t_q;
	logic [3*POS_W-1:0] p_q;
	logic [3*VEL_W-1:0] v_q;

	// capture on entry to valid, and again when the held result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_q <= 1'b0;
		else hold_q <= out.valid;
	end
	always_ff @(posedge clk) begin
		if (!hold_q || !out.valid) begin
			st_q <= res_status;
			t_q  <= r_time;
			p_q  <= r_pos;
			v_q  <= r_vel;
		end else if (out.ready) begin
			st_q <= res_status;
			t_q  <= r_time;
			p_q  <= r_pos;
			v_q  <= r_vel;
		end
	end

	assign out.status = (hold_q && out.valid) ? st_q : res_status;
	assign out.out_time = (hold_q && out.valid) ? t_q : r_time;
	assign {out.out_pos_x, out.out_pos_y, out.out_pos_z} = (hold_q && out.valid) ? p_q : r_pos;
	assign {out.out_vel_x, out.out_vel_y, out.out_vel_z} = (hold_q && out.valid) ? v_q : r_vel;
endmodule

[design/tsi_checker.sv]
// Port-level checker for the interpolator core, bound to the top level.
// Depends on tsi_pkg.
module tsi_checker import tsi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] status
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped under stall");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'd4)
		else $error("bad status code");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result before work done");
endmodule

bind tabulated_state_interpolator_core tsi_checker u_tsi_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready),
	.status(out.status)
);
